// File: rtl/oawa_pkg.sv
// ============================================================================
// oawa_pkg: shared types and constants of the oversampling average block
// widths, register indexes, channel payloads and the control state type
// ============================================================================
`default_nettype none

package oawa_pkg;

    // adc conversion width
    localparam int SAMPLE_BITS = 12;
    // oversample count register width
    localparam int COUNT_W     = 8;
    // burst sum: up to 255 full-scale conversions
    localparam int SUM_W       = SAMPLE_BITS + COUNT_W;
    // bit step counter of the serial units
    localparam int STEP_W      = $clog2(SUM_W);
    // configuration data: widest register
    localparam int CFG_W       = (SAMPLE_BITS > COUNT_W) ? SAMPLE_BITS : COUNT_W;
    localparam int CFG_IDX_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OVERSAMPLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WIN_LOW    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WIN_HIGH   = CFG_IDX_W'(2);

    localparam logic [COUNT_W-1:0] OVERSAMPLE_RESET = COUNT_W'(16);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   conversion_ok;
    } oawa_in_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] average;
        logic                   out_of_window;
        logic                   alarm_event;
    } oawa_out_t;

    // control of the serial accumulator
    typedef struct packed {
        logic start;
        logic clear;
    } oawa_acc_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV
    } oawa_state_t;

endpackage

`default_nettype wire

// File: rtl/oawa_acc.sv
// ============================================================================
// oawa_acc: bit-serial burst accumulator
// adds one conversion into the burst sum, one bit per cycle, lsb first
// ============================================================================
`default_nettype none

module oawa_acc
    import oawa_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire oawa_acc_ctl_t          ctl,
    input  wire logic [SAMPLE_BITS-1:0] addend,
    output logic      [SUM_W-1:0]       sum,
    output logic                        busy
);

    logic [SUM_W-1:0]       sum_reg,    sum_next;
    logic [SAMPLE_BITS-1:0] addend_reg, addend_next;
    logic                   carry_reg,  carry_next;
    logic [STEP_W-1:0]      step_reg,   step_next;
    logic                   busy_reg,   busy_next;
    logic                   bit_a;
    logic                   bit_b;

    always_comb begin
        bit_a       = sum_reg[0];
        bit_b       = addend_reg[0];
        sum_next    = sum_reg;
        addend_next = addend_reg;
        carry_next  = carry_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        if (ctl.start) begin
            addend_next = addend;
            carry_next  = 1'b0;
            step_next   = STEP_W'(SUM_W - 1);
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            // sum rotates right, the new bit enters at the top
            sum_next    = {bit_a ^ bit_b ^ carry_reg, sum_reg[SUM_W-1:1]};
            addend_next = {1'b0, addend_reg[SAMPLE_BITS-1:1]};
            carry_next  = (bit_a & bit_b) | (carry_reg & (bit_a ^ bit_b));
            step_next   = step_reg - STEP_W'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
            end
        end else if (ctl.clear) begin
            sum_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            carry_reg <= 1'b0;
            step_reg  <= '0;
            busy_reg  <= 1'b0;
        end else begin
            sum_reg   <= sum_next;
            carry_reg <= carry_next;
            step_reg  <= step_next;
            busy_reg  <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        addend_reg <= addend_next;
    end

    assign sum  = sum_reg;
    assign busy = busy_reg;

endmodule

`default_nettype wire

// File: rtl/oawa_div.sv
// ============================================================================
// oawa_div: serial restoring divider
// one quotient bit per cycle, msb first, narrow remainder datapath
// ============================================================================
`default_nettype none

module oawa_div
    import oawa_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [SUM_W-1:0]   dividend,
    input  wire logic [COUNT_W-1:0] divisor,
    output logic      [SUM_W-1:0]   quotient,
    output logic                    busy
);

    logic [SUM_W-1:0]   quo_reg,  quo_next;
    logic [COUNT_W-1:0] rem_reg,  rem_next;
    logic [COUNT_W-1:0] dvs_reg,  dvs_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               busy_reg, busy_next;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W-1:0] diff;
    logic               fits;

    always_comb begin
        // remainder stays below the divisor, so the trial fits in one extra bit
        trial     = {rem_reg, quo_reg[SUM_W-1]};
        // a fitting trial leaves a difference below the divisor
        diff      = trial[COUNT_W-1:0] - dvs_reg;
        fits      = (trial >= {1'b0, dvs_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(SUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? diff : trial[COUNT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

`default_nettype wire

// File: rtl/oversample_average_window_alarm_top.sv
// ============================================================================
// oversample_average_window_alarm_top: oversampling average with window alarm
// sums a burst of adc conversions, divides by the burst length and checks
// the average against an inclusive window, with a latched alarm
// ============================================================================
//
//   channel   ports                         payload / fields
//   -------   ---------------------------   -----------------------------------
//   input     s_valid, s_ready, s_payload   sample, conversion_ok
//   result    m_valid, m_ready, m_payload   average, out_of_window, alarm_event
//   config    cfg_wr_en, cfg_index,         0 oversample_count, 1 window_low,
//             cfg_wdata                     2 window_high
//
// an ordinary conversion is done once the bit-serial add has put it into the
// burst sum; the conversion that closes a burst then also goes through the
// bit-serial restoring divide
// one request in flight at a time; s_ready is high only while idle
// a result waits in the output register while the next request is taken;
// a finished average waits in the divider while that register is still full
// reset is synchronous: sum, count, alarm latch and registers go to defaults
// ============================================================================
`default_nettype none

module oversample_average_window_alarm_top
    import oawa_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire oawa_in_t             s_payload,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output oawa_out_t                 m_payload,

    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_wdata
);

    // configuration registers
    logic [COUNT_W-1:0]     count_reg;
    logic [SAMPLE_BITS-1:0] win_low_reg;
    logic [SAMPLE_BITS-1:0] win_high_reg;

    // control state
    oawa_state_t            state_reg,     state_next;
    logic [COUNT_W-1:0]     taken_reg,     taken_next;
    logic                   burst_end_reg, burst_end_next;
    logic                   alarm_reg,     alarm_next;
    logic                   m_valid_reg,   m_valid_next;
    oawa_out_t              m_payload_reg, m_payload_next;

    // serial units
    oawa_acc_ctl_t          acc_ctl;
    logic [SAMPLE_BITS-1:0] acc_addend;
    logic [SUM_W-1:0]       acc_sum;
    logic                   acc_busy;
    logic                   div_start;
    logic [SUM_W-1:0]       div_quo;
    logic                   div_busy;

    // datapath helpers
    logic [COUNT_W-1:0]     n_eff;
    logic [COUNT_W:0]       taken_inc;
    logic                   out_free;
    logic [SAMPLE_BITS-1:0] avg;
    logic                   outside;
    logic                   event_hit;

    // ------------------------------------------------------------------
    // configuration writes, taken only while idle by contract
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= OVERSAMPLE_RESET;
            win_low_reg  <= '0;
            win_high_reg <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_OVERSAMPLE: count_reg    <= cfg_wdata[COUNT_W-1:0];
                REG_WIN_LOW:    win_low_reg  <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_WIN_HIGH:   win_high_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // a zero count behaves as one
    assign n_eff     = (count_reg == '0) ? COUNT_W'(1) : count_reg;
    assign taken_inc = {1'b0, taken_reg} + (COUNT_W + 1)'(1);

    // failed conversions still count but add nothing
    assign acc_addend = s_payload.conversion_ok ? s_payload.sample : '0;

    // quotient beyond full scale only happens when the count drops mid-burst
    assign avg       = (|div_quo[SUM_W-1:SAMPLE_BITS]) ? '1 : div_quo[SAMPLE_BITS-1:0];
    assign outside   = (avg < win_low_reg) || (avg > win_high_reg);
    assign event_hit = outside && !alarm_reg;

    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // sequencer: idle -> add -> (divide ->) idle
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        taken_next     = taken_reg;
        burst_end_next = burst_end_reg;
        alarm_next     = alarm_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        s_ready        = 1'b0;
        acc_ctl        = '0;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    acc_ctl.start  = 1'b1;
                    // burst closes once taken reaches the current count
                    burst_end_next = (taken_inc >= {1'b0, n_eff});
                    taken_next     = (taken_inc >= {1'b0, n_eff}) ? '0
                                                                   : taken_inc[COUNT_W-1:0];
                    state_next     = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!acc_busy) begin
                    if (burst_end_reg) begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV: begin
                // hold the quotient until the output register frees up
                if (!div_busy && out_free) begin
                    m_valid_next                 = 1'b1;
                    m_payload_next.average       = avg;
                    m_payload_next.out_of_window = outside;
                    m_payload_next.alarm_event   = event_hit;
                    // latch sets on an event, clears once back inside
                    alarm_next                   = event_hit ? 1'b1
                                                 : (outside ? alarm_reg : 1'b0);
                    acc_ctl.clear                = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taken_reg     <= '0;
            burst_end_reg <= 1'b0;
            alarm_reg     <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            taken_reg     <= taken_next;
            burst_end_reg <= burst_end_next;
            alarm_reg     <= alarm_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ------------------------------------------------------------------
    // serial units
    // ------------------------------------------------------------------
    oawa_acc u_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (acc_ctl),
        .addend  (acc_addend),
        .sum     (acc_sum),
        .busy    (acc_busy)
    );

    oawa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_sum),
        .divisor  (n_eff),
        .quotient (div_quo),
        .busy     (div_busy)
    );

endmodule

`default_nettype wire

// File: rtl/oawa_check.sv
// ============================================================================
// oawa_check: port-level checks of the oversampling average block
// watches the handshakes and result fields over time
// ============================================================================
`default_nettype none

module oawa_check
    import oawa_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire oawa_out_t m_payload
);

    // one request at a time: ready drops right after a request is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a request is in flight");

    // an alarm pulse always comes with an out-of-window average
    a_alarm_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_payload.alarm_event || m_payload.out_of_window))
        else $error("alarm event without out-of-window average");

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a stalled result stays up
    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before accepted");

    // a stalled result keeps its payload
    a_payload_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_payload))
        else $error("result payload changed while stalled");

endmodule

bind oversample_average_window_alarm_top oawa_check u_oawa_check (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire
